### rtl/core/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and constants of the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // command codes carried in req_type
  localparam logic [2:0] REQ_INIT     = 3'd0;
  localparam logic [2:0] REQ_START    = 3'd1;
  localparam logic [2:0] REQ_WRITE    = 3'd2;
  localparam logic [2:0] REQ_STOP     = 3'd3;
  localparam logic [2:0] REQ_READ_REQ = 3'd4;
  localparam logic [2:0] REQ_READ     = 3'd5;

  // pin writes per phase
  localparam int unsigned InitSteps  = 2;
  localparam int unsigned StartSteps = 4;
  localparam int unsigned SendSteps  = 27;
  localparam int unsigned BitSteps   = 24;
  localparam int unsigned StopSteps  = 3;
  localparam int unsigned ReadSteps  = 20;
  localparam int unsigned ReadClocks = 16;

  localparam logic [7:0] MIN_READ_LEN = 8'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] slave_address;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic [7:0] slave_bits;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_data;
    logic       accepted;
    logic       last;
  } out_t;

  // level source for one pin write
  typedef enum logic [2:0] {
    LVL_LOW  = 3'd0,
    LVL_HIGH = 3'd1,
    LVL_BIT  = 3'd2,
    LVL_ACK  = 3'd3,
    LVL_HOLD = 3'd4
  } lvl_t;

  // controller to datapath
  typedef struct packed {
    logic issue;
    logic pin_scl;
    lvl_t lvl;
    logic last;
    logic show_data;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_start;
    logic short_len;
    logic out_busy;
  } stat_t;

endpackage

### rtl/core/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// phase state machine and step counter, issues one pin write per step
// ----------------------------------------------------------------------------
module i2cms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [2:0]        req_type,
  input  i2cms_pkg::stat_t  stat,
  output logic              idle,
  output i2cms_pkg::cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_START = 7'b0000100,
    S_SEND  = 7'b0001000,
    S_STOP  = 7'b0010000,
    S_RBODY = 7'b0100000,
    S_SHORT = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] ph, ph_next;
  logic       then_read, then_read_next;
  logic       step_go;

  assign idle    = (state == S_IDLE);
  assign step_go = (state != S_IDLE) && !stat.out_busy;

  always_comb begin
    logic   fin;
    state_t nxt;
    fin            = 1'b0;
    nxt            = S_IDLE;
    state_next     = state;
    cnt_next       = cnt;
    ph_next        = ph;
    then_read_next = then_read;
    cmd            = '0;
    cmd.lvl        = i2cms_pkg::LVL_HOLD;
    cmd.issue      = step_go;
    case (state)
      S_IDLE: begin
        cmd.issue = 1'b0;
        if (in_fire) begin
          cnt_next       = '0;
          ph_next        = '0;
          then_read_next = 1'b0;
          case (req_type)
            i2cms_pkg::REQ_INIT:  state_next = S_INIT;
            i2cms_pkg::REQ_START: state_next = S_START;
            i2cms_pkg::REQ_WRITE: state_next = S_SEND;
            i2cms_pkg::REQ_STOP:  state_next = S_STOP;
            i2cms_pkg::REQ_READ_REQ: begin
              state_next = stat.short_len ? S_SHORT : S_START;
            end
            i2cms_pkg::REQ_READ: begin
              then_read_next = stat.need_start;
              state_next     = stat.need_start ? S_START : S_RBODY;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        cmd.pin_scl = cnt[0];
        cmd.lvl     = i2cms_pkg::LVL_LOW;
        fin         = (cnt == 5'(i2cms_pkg::InitSteps - 1));
        cmd.last    = fin;
        nxt         = S_IDLE;
      end
      S_START: begin
        // sda high, scl high, sda low, scl low
        cmd.pin_scl = cnt[0];
        cmd.lvl     = cnt[1] ? i2cms_pkg::LVL_LOW : i2cms_pkg::LVL_HIGH;
        fin         = (cnt == 5'(i2cms_pkg::StartSteps - 1));
        nxt         = S_SEND;
      end
      S_SEND: begin
        if (cnt == '0) begin
          cmd.pin_scl = 1'b1;
          cmd.lvl     = i2cms_pkg::LVL_LOW;
        end else if (cnt <= 5'(i2cms_pkg::BitSteps)) begin
          case (ph)
            2'd0: begin
              cmd.pin_scl = 1'b0;
              cmd.lvl     = i2cms_pkg::LVL_BIT;
            end
            2'd1: begin
              cmd.pin_scl = 1'b1;
              cmd.lvl     = i2cms_pkg::LVL_HIGH;
            end
            default: begin
              cmd.pin_scl = 1'b1;
              cmd.lvl     = i2cms_pkg::LVL_LOW;
            end
          endcase
          if (step_go) begin
            ph_next = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
          end
        end else if (cnt == 5'(i2cms_pkg::BitSteps + 1)) begin
          cmd.pin_scl = 1'b1;
          cmd.lvl     = i2cms_pkg::LVL_HIGH;
        end else begin
          cmd.pin_scl = 1'b1;
          cmd.lvl     = i2cms_pkg::LVL_LOW;
        end
        fin      = (cnt == 5'(i2cms_pkg::SendSteps - 1));
        cmd.last = fin && !then_read;
        nxt      = then_read ? S_RBODY : S_IDLE;
      end
      S_RBODY: begin
        if (cnt == '0) begin
          cmd.pin_scl = 1'b0;
          cmd.lvl     = i2cms_pkg::LVL_HIGH;
        end else if (cnt <= 5'(i2cms_pkg::ReadClocks)) begin
          cmd.pin_scl = 1'b1;
          cmd.lvl     = cnt[0] ? i2cms_pkg::LVL_HIGH : i2cms_pkg::LVL_LOW;
        end else if (cnt == 5'(i2cms_pkg::ReadClocks + 1)) begin
          cmd.pin_scl = 1'b0;
          cmd.lvl     = i2cms_pkg::LVL_ACK;
        end else if (cnt == 5'(i2cms_pkg::ReadClocks + 2)) begin
          cmd.pin_scl = 1'b1;
          cmd.lvl     = i2cms_pkg::LVL_HIGH;
        end else begin
          cmd.pin_scl = 1'b1;
          cmd.lvl     = i2cms_pkg::LVL_LOW;
        end
        fin           = (cnt == 5'(i2cms_pkg::ReadSteps - 1));
        cmd.last      = fin;
        cmd.show_data = fin;
        nxt           = S_IDLE;
      end
      S_STOP: begin
        // sda low, scl high, sda high
        cmd.pin_scl = cnt[0];
        cmd.lvl     = (cnt == '0) ? i2cms_pkg::LVL_LOW : i2cms_pkg::LVL_HIGH;
        fin         = (cnt == 5'(i2cms_pkg::StopSteps - 1));
        cmd.last    = fin;
        nxt         = S_IDLE;
      end
      S_SHORT: begin
        cmd.lvl  = i2cms_pkg::LVL_HOLD;
        fin      = 1'b1;
        cmd.last = 1'b1;
        nxt      = S_IDLE;
      end
      default: begin
        cmd.issue  = 1'b0;
        state_next = S_IDLE;
      end
    endcase
    if (step_go) begin
      if (fin) begin
        state_next = nxt;
        cnt_next   = '0;
        ph_next    = '0;
      end else begin
        cnt_next = cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ph        <= '0;
      then_read <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      ph        <= ph_next;
      then_read <= then_read_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 5'(i2cms_pkg::SendSteps - 1))
    else $error("step counter out of range");

  a_ph_send_only: assert property (@(posedge clk) disable iff (rst)
    ph != 2'd0 |-> state == S_SEND)
    else $error("bit phase active outside byte send");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && cmd.last |=> state == S_IDLE)
    else $error("run did not end after last pin write");

  a_no_step_when_busy: assert property (@(posedge clk) disable iff (rst)
    stat.out_busy |-> !cmd.issue)
    else $error("pin write issued while result held");

endmodule

### rtl/core/i2cms_dp.sv
// ----------------------------------------------------------------------------
// i2cms_dp
// bus state, shift register and result register
// ----------------------------------------------------------------------------
module i2cms_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  i2cms_pkg::in_t    item,
  input  i2cms_pkg::cmd_t   cmd,
  input  logic              out_stall,
  output i2cms_pkg::stat_t  stat,
  output logic              out_valid,
  output i2cms_pkg::out_t   out_item
);

  logic [6:0] target_address;
  logic [7:0] bytes_remaining;
  logic       need_start;
  logic       scl_now;
  logic       sda_now;
  logic [7:0] shreg;
  logic [7:0] rd_bits;
  logic       nack;
  logic       acc;

  logic [7:0] rem_dec;
  logic       len_ok;
  logic       level;
  logic       scl_next;
  logic       sda_next;

  assign rem_dec = bytes_remaining - {7'd0, (bytes_remaining != 8'd0)};
  assign len_ok  = (item.read_length >= i2cms_pkg::MIN_READ_LEN);

  assign stat.need_start = need_start;
  assign stat.short_len  = !len_ok;
  assign stat.out_busy   = out_valid && out_stall;

  always_comb begin
    case (cmd.lvl)
      i2cms_pkg::LVL_LOW:  level = 1'b0;
      i2cms_pkg::LVL_HIGH: level = 1'b1;
      i2cms_pkg::LVL_BIT:  level = shreg[7];
      i2cms_pkg::LVL_ACK:  level = nack;
      default:             level = cmd.pin_scl ? scl_now : sda_now;
    endcase
    scl_next = cmd.pin_scl ? level : scl_now;
    sda_next = cmd.pin_scl ? sda_now : level;
  end

  // bus and command state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_address  <= '0;
      bytes_remaining <= '0;
      need_start      <= 1'b1;
      scl_now         <= 1'b1;
      sda_now         <= 1'b1;
    end else begin
      if (cmd.issue) begin
        scl_now <= scl_next;
        sda_now <= sda_next;
      end
      if (in_fire) begin
        case (item.req_type)
          i2cms_pkg::REQ_START: target_address <= item.slave_address;
          i2cms_pkg::REQ_READ_REQ: begin
            if (len_ok) begin
              target_address  <= item.slave_address;
              bytes_remaining <= item.read_length;
              need_start      <= 1'b0;
            end
          end
          i2cms_pkg::REQ_READ: begin
            bytes_remaining <= rem_dec;
            if (rem_dec == 8'd0) begin
              need_start <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // per item working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_bits <= item.slave_bits;
      nack    <= (rem_dec == 8'd0);
      acc     <= (item.req_type == i2cms_pkg::REQ_READ_REQ) && len_ok;
      case (item.req_type)
        i2cms_pkg::REQ_START:    shreg <= {item.slave_address, 1'b0};
        i2cms_pkg::REQ_READ_REQ: shreg <= {item.slave_address, 1'b1};
        i2cms_pkg::REQ_READ:     shreg <= {target_address, 1'b1};
        default:                 shreg <= item.write_data;
      endcase
    end else if (cmd.issue && cmd.lvl == i2cms_pkg::LVL_BIT) begin
      shreg <= {shreg[6:0], 1'b0};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      out_item.scl_level <= scl_next;
      out_item.sda_level <= sda_next;
      out_item.read_data <= cmd.show_data ? rd_bits : 8'd0;
      out_item.accepted  <= acc;
      out_item.last      <= cmd.last;
    end
  end

endmodule

### rtl/core/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// turns i2c master commands into the ordered run of scl/sda pin writes
// ----------------------------------------------------------------------------
// usage
//   req channel: one command item (req_type, address, data, length, sampled
//   read bits) is taken when req_valid is high and req_stall is low
//   rsp channel: one item per pin write, holding the scl and sda levels after
//   that write; last marks the final item of a command's run
//   a command yields 2 (init), 3 (stop), 27 (write byte), 31 (start),
//   1 or 31 (read request), 20 or 51 (read byte) items, or none for an
//   unknown code; with no stall one item leaves per cycle, the first one
//   after the command passes the controller state and result registers
//   the next command is taken the cycle after the last pin write of the
//   current one is issued
//   a stalled rsp item holds in the result register and the sequencer waits
//   reset puts both pins high (bus idle), clears address and read count and
//   marks that the next read must begin with a start
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  i2cms_pkg::in_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output i2cms_pkg::out_t  rsp
);

  i2cms_pkg::cmd_t  cmd;
  i2cms_pkg::stat_t stat;
  logic             idle;
  logic             in_fire;

  // commands are taken only between runs
  assign req_stall = !idle;
  assign in_fire   = req_valid && idle;

  // phase sequencing: one pin write per step
  i2cms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .req_type (req.req_type),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  // bus state, shift register and result register
  i2cms_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .item      (req),
    .cmd       (cmd),
    .out_stall (rsp_stall),
    .stat      (stat),
    .out_valid (rsp_valid),
    .out_item  (rsp)
  );

endmodule

### tb/i2c_master_bit_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// self-checking bench: commands in, predicted scl/sda pin writes compared out
// ----------------------------------------------------------------------------
// a local model of the sequencer expands every command item into the pin
// writes it must cause; each rsp item is checked against the oldest of them.
// directed commands cover the field extremes and the read corner cases, then
// random bus transactions run under three idling mixes and one long receiver
// hold that backs the sequencer up into its command input
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the sequencer must ignore
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 64;
  localparam int REPORT_LIMIT  = 10;

  logic            clk;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  i2cms_pkg::in_t  req = '0;
  logic            rsp_valid;
  logic            rsp_stall = 1'b0;
  i2cms_pkg::out_t rsp;

  i2c_master_bit_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the handshakes lock up
  initial begin
    #1000000;
    $display("** i2c_master_bit_sequencer: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // bus model: pin levels, address, read count and start flag
  // --------------------------------------------------------------------------
  logic [6:0] bus_target;
  logic [7:0] bus_bytes_left;
  logic       bus_start_due;
  logic       bus_scl;
  logic       bus_sda;
  logic       bus_accept;

  i2cms_pkg::out_t pin_writes_due[$];   // pin writes still owed by the sequencer
  i2cms_pkg::out_t cmd_pins[$];         // pin writes of the command being expanded

  int mismatch_count = 0;

  function automatic void reset_bus_model();
    bus_target     = '0;
    bus_bytes_left = '0;
    bus_start_due  = 1'b1;
    bus_scl        = 1'b1;
    bus_sda        = 1'b1;
    pin_writes_due.delete();
  endfunction

  // one pin write, logging both levels as they stand afterwards
  function automatic void write_pin(bit on_scl, bit level);
    i2cms_pkg::out_t p;
    if (on_scl) bus_scl = level;
    else bus_sda = level;
    p           = '0;
    p.scl_level = bus_scl;
    p.sda_level = bus_sda;
    p.accepted  = bus_accept;
    cmd_pins.push_back(p);
  endfunction

  function automatic void start_pins();
    write_pin(1'b0, 1'b1);
    write_pin(1'b1, 1'b1);
    write_pin(1'b0, 1'b0);
    write_pin(1'b1, 1'b0);
  endfunction

  // msb first, then one clock for the slave's ack
  function automatic void byte_pins(logic [7:0] value);
    write_pin(1'b1, 1'b0);
    for (int b = 7; b >= 0; b--) begin
      write_pin(1'b0, value[b]);
      write_pin(1'b1, 1'b1);
      write_pin(1'b1, 1'b0);
    end
    write_pin(1'b1, 1'b1);
    write_pin(1'b1, 1'b0);
  endfunction

  // expand one accepted command into the pin writes it owes
  function automatic void expand_command(i2cms_pkg::in_t c);
    i2cms_pkg::out_t p;
    cmd_pins.delete();
    bus_accept = 1'b0;
    case (c.req_type)
      i2cms_pkg::REQ_INIT: begin
        write_pin(1'b0, 1'b0);
        write_pin(1'b1, 1'b0);
      end
      i2cms_pkg::REQ_START: begin
        bus_target = c.slave_address;
        start_pins();
        byte_pins({c.slave_address, 1'b0});
      end
      i2cms_pkg::REQ_WRITE: byte_pins(c.write_data);
      i2cms_pkg::REQ_STOP: begin
        write_pin(1'b0, 1'b0);
        write_pin(1'b1, 1'b1);
        write_pin(1'b0, 1'b1);
      end
      i2cms_pkg::REQ_READ_REQ: begin
        if (c.read_length < i2cms_pkg::MIN_READ_LEN) begin
          // too short: echo the present levels, nothing else moves
          p           = '0;
          p.scl_level = bus_scl;
          p.sda_level = bus_sda;
          cmd_pins.push_back(p);
        end else begin
          bus_accept = 1'b1;
          start_pins();
          byte_pins({c.slave_address, 1'b1});
          bus_target     = c.slave_address;
          bus_bytes_left = c.read_length;
          bus_start_due  = 1'b0;
        end
      end
      i2cms_pkg::REQ_READ: begin
        // a read with no open request restarts towards the stored address
        if (bus_start_due) begin
          start_pins();
          byte_pins({bus_target, 1'b1});
        end
        if (bus_bytes_left != 8'd0) bus_bytes_left = bus_bytes_left - 8'd1;
        if (bus_bytes_left == 8'd0) bus_start_due = 1'b1;
        write_pin(1'b0, 1'b1);
        for (int k = 0; k < 8; k++) begin
          write_pin(1'b1, 1'b1);
          write_pin(1'b1, 1'b0);
        end
        // ack while bytes remain, nack on the final one
        write_pin(1'b0, bus_bytes_left == 8'd0);
        write_pin(1'b1, 1'b1);
        write_pin(1'b1, 1'b0);
      end
      default: ;
    endcase
    if (cmd_pins.size() != 0) begin
      p      = cmd_pins.pop_back();
      p.last = 1'b1;
      if (c.req_type == i2cms_pkg::REQ_READ) p.read_data = c.slave_bits;
      cmd_pins.push_back(p);
    end
    foreach (cmd_pins[i]) pin_writes_due.push_back(cmd_pins[i]);
  endfunction

  // --------------------------------------------------------------------------
  // receiver: random stalls, or a long hold when one is asked for
  // --------------------------------------------------------------------------
  int rcv_idle_pct = 0;
  bit hold_toggle  = 1'b0;
  bit hold_seen    = 1'b0;
  int hold_left    = 0;

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  i2cms_pkg::out_t pin_want;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pin_writes_due.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected pin write: scl %0b sda %0b data %02h acc %0b last %0b",
                   rsp.scl_level, rsp.sda_level, rsp.read_data, rsp.accepted,
                   rsp.last);
        mismatch_count <= mismatch_count + 1;
      end else begin
        pin_want = pin_writes_due.pop_front();
        if (rsp.scl_level !== pin_want.scl_level ||
            rsp.sda_level !== pin_want.sda_level ||
            rsp.read_data !== pin_want.read_data ||
            rsp.accepted !== pin_want.accepted ||
            rsp.last !== pin_want.last) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("pin write mismatch at %0t", $realtime);
            $display("  want scl %0b sda %0b data %02h acc %0b last %0b",
                     pin_want.scl_level, pin_want.sda_level, pin_want.read_data,
                     pin_want.accepted, pin_want.last);
            $display("  got  scl %0b sda %0b data %02h acc %0b last %0b",
                     rsp.scl_level, rsp.sda_level, rsp.read_data, rsp.accepted,
                     rsp.last);
          end
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  int snd_idle_pct = 0;

  // present one command and wait for it to be taken
  task automatic offer_command(i2cms_pkg::in_t c);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < snd_idle_pct) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= c;
    req_valid <= 1'b1;
    expand_command(c);
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  function automatic i2cms_pkg::in_t cmd_fields(logic [2:0] code, logic [6:0] addr,
                                                logic [7:0] wdata, logic [7:0] len,
                                                logic [7:0] bits);
    i2cms_pkg::in_t c;
    c.req_type      = code;
    c.slave_address = addr;
    c.write_data    = wdata;
    c.read_length   = len;
    c.slave_bits    = bits;
    return c;
  endfunction

  function automatic i2cms_pkg::in_t random_command(logic [2:0] code);
    return cmd_fields(code, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  task automatic set_idling(int snd_pct, int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // plain bus commands, address and data extremes; the very first read
  // comes straight out of reset so it must start towards address zero
  task automatic test_bus_commands();
    offer_command(cmd_fields(i2cms_pkg::REQ_READ, 7'h00, 8'h00, 8'h00, 8'hA5));
    offer_command(cmd_fields(i2cms_pkg::REQ_INIT, 7'h7F, 8'hFF, 8'hFF, 8'hFF));
    offer_command(cmd_fields(i2cms_pkg::REQ_START, 7'h7F, 8'h00, 8'h00, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_WRITE, 7'h00, 8'hFF, 8'h00, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_WRITE, 7'h7F, 8'h00, 8'hFF, 8'hFF));
    offer_command(cmd_fields(i2cms_pkg::REQ_STOP, 7'h00, 8'h00, 8'h00, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_START, 7'h00, 8'hFF, 8'hFF, 8'hFF));
    offer_command(cmd_fields(i2cms_pkg::REQ_WRITE, 7'h55, 8'h5A, 8'h00, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_STOP, 7'h7F, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // short requests, a full two-byte read, a read with nothing pending,
  // and a long request cut short
  task automatic test_read_requests();
    offer_command(cmd_fields(i2cms_pkg::REQ_READ_REQ, 7'h7F, 8'h00, 8'h00, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_READ_REQ, 7'h12, 8'hFF, 8'h01, 8'hFF));
    offer_command(cmd_fields(i2cms_pkg::REQ_READ_REQ, 7'h7F, 8'h00, 8'h02, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_READ, 7'h00, 8'h00, 8'h00, 8'hFF));
    offer_command(cmd_fields(i2cms_pkg::REQ_READ, 7'h00, 8'h00, 8'h00, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_READ, 7'h00, 8'h00, 8'h00, 8'h3C));
    offer_command(cmd_fields(i2cms_pkg::REQ_READ_REQ, 7'h2A, 8'h00, 8'hFF, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_READ, 7'h55, 8'hAA, 8'h00, 8'hC3));
    offer_command(cmd_fields(i2cms_pkg::REQ_STOP, 7'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // spare codes must leave no trace, the following init proves the levels
  task automatic test_unknown_codes();
    offer_command(cmd_fields(REQ_SPARE_A, 7'h7F, 8'hFF, 8'hFF, 8'hFF));
    offer_command(cmd_fields(REQ_SPARE_B, 7'h00, 8'h00, 8'h00, 8'h00));
    offer_command(cmd_fields(i2cms_pkg::REQ_INIT, 7'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // mostly well-formed transactions with random content, some noise
  task automatic test_random_traffic(int goal);
    int             sent;
    int             pick;
    int             len;
    int             reads;
    i2cms_pkg::in_t c;
    sent = 0;
    while (sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // read transaction, now and then overrunning or cut short
        if ($urandom_range(0, 3) == 0) begin
          offer_command(random_command(i2cms_pkg::REQ_INIT));
          sent++;
        end
        c   = random_command(i2cms_pkg::REQ_READ_REQ);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 5);
        c.read_length = 8'(len);
        offer_command(c);
        sent++;
        reads = (len > 5) ? $urandom_range(1, 4) : len + ($urandom_range(0, 4) == 0);
        repeat (reads) begin
          offer_command(random_command(i2cms_pkg::REQ_READ));
          sent++;
        end
        offer_command(random_command(i2cms_pkg::REQ_STOP));
        sent++;
      end else if (pick < 80) begin
        // write transaction
        offer_command(random_command(i2cms_pkg::REQ_START));
        sent++;
        repeat ($urandom_range(1, 4)) begin
          offer_command(random_command(i2cms_pkg::REQ_WRITE));
          sent++;
        end
        offer_command(random_command(i2cms_pkg::REQ_STOP));
        sent++;
      end else if (pick < 90) begin
        // rejected request, then a read on whatever state is left
        c = random_command(i2cms_pkg::REQ_READ_REQ);
        c.read_length = 8'($urandom_range(0, 1));
        offer_command(c);
        offer_command(random_command(i2cms_pkg::REQ_READ));
        sent += 2;
      end else begin
        c = random_command(3'($urandom_range(0, 7)));
        offer_command(c);
        if (c.req_type <= i2cms_pkg::REQ_READ) sent++;
      end
    end
  endtask

  // receiver holds off while writes keep coming, so the command input backs up
  task automatic test_receiver_backlog();
    hold_toggle <= ~hold_toggle;
    repeat (8) offer_command(random_command(i2cms_pkg::REQ_WRITE));
  endtask

  initial begin
    reset_bus_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_idling(34, 49);
    test_bus_commands();
    test_read_requests();
    test_unknown_codes();
    test_random_traffic(110);

    set_idling(49, 34);
    test_random_traffic(110);

    set_idling(0, 0);
    test_receiver_backlog();
    test_random_traffic(90);
    req_valid <= 1'b0;

    // let every owed pin write drain, then watch for stragglers
    while (pin_writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pin_writes_due.size() == 0) begin
      $display("** i2c_master_bit_sequencer: PASSED **");
    end else begin
      $display("** i2c_master_bit_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
